// ===== rtl/crc16_control_char_framer_assert.svh =====
// ----------------------------------------------------------------------------
// crc16_control_char_framer assertion macros
// Clocked property macros shared by the framer rtl; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef CRC16_CONTROL_CHAR_FRAMER_ASSERT_SVH
`define CRC16_CONTROL_CHAR_FRAMER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define CFR_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define CFR_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define CFR_ASSERT_NOW(name, ante, cons, msg)
`define CFR_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ===== rtl/crcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfr_pkg
// Types and constants for the crc-16 control character framer.
// ----------------------------------------------------------------------------
package crcfr_pkg;

	typedef enum logic {
		OP_APPEND = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_REJECT   = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data_byte;
		logic       last;
	} req_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_valid;
		logic       frame_end;
		status_t    status;
	} res_t;

	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [7:0]  CH_SOH   = 8'h01;
	localparam logic [7:0]  CH_STX   = 8'h02;
	localparam logic [7:0]  CH_ETX   = 8'h03;
	localparam logic [7:0]  CH_EOT   = 8'h04;

endpackage

// ===== rtl/crcfr_store.sv =====
// ----------------------------------------------------------------------------
// crcfr_store
// Payload byte memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module crcfr_store #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/crc16_control_char_framer.sv =====
// ----------------------------------------------------------------------------
// crc16_control_char_framer
// Buffers payload bytes under a running crc-16/modbus and drains them as one
// control character frame: SOH, crc low, crc high, STX, payload, ETX, EOT.
// ----------------------------------------------------------------------------
// Each request is taken at the edge where start is high and busy is low, and
// its result appears on result with done high for exactly the following cycle,
// during which busy is high. Both the result and the read of the payload memory
// are registered, and every request waits out that registered read so that
// results stay in order. The receiver cannot stall: a result must be captured
// in its done cycle. No clearing pass is needed after reset; only stored
// payload entries are ever read back.
module crc16_control_char_framer #(
	parameter int PAYLOAD_DEPTH = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  crcfr_pkg::req_t request,
	output logic            busy,
	output logic            done,
	output crcfr_pkg::res_t result
);

	`include "crc16_control_char_framer_assert.svh"

	localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
	localparam int CW = $clog2(PAYLOAD_DEPTH + 1);
	localparam int PW = $clog2(PAYLOAD_DEPTH + 6);

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
			input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ crcfr_pkg::CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	logic [CW-1:0]   count_q, count_d;
	logic [15:0]     crc_q, crc_d;
	logic            pending_q, pending_d;
	logic [PW-1:0]   pos_q, pos_d;

	logic            valid_s1;
	logic            mem_sel_s1, mem_sel_d;
	crcfr_pkg::res_t res_s1, res_d;

	logic            accept;
	logic            room;
	logic [PW-1:0]   count_ext;
	logic [PW-1:0]   pos_off;
	logic            mem_we;
	logic [7:0]      mem_rdata;

	assign accept    = start && !busy;
	assign room      = count_q < CW'(PAYLOAD_DEPTH);
	assign count_ext = PW'(count_q);
	assign pos_off   = pos_q - PW'(4);

	always_comb begin
		count_d   = count_q;
		crc_d     = crc_q;
		pending_d = pending_q;
		pos_d     = pos_q;
		mem_sel_d = 1'b0;
		mem_we    = 1'b0;
		res_d     = '{frame_byte: 8'h00, frame_valid: 1'b0, frame_end: 1'b0,
			status: crcfr_pkg::ST_OK};
		if (accept) begin
			if (request.op == crcfr_pkg::OP_APPEND) begin
				if (pending_q) begin
					res_d.status = crcfr_pkg::ST_REJECT;
				end else begin
					if (room) begin
						mem_we  = 1'b1;
						crc_d   = crc_byte(crc_q, request.data_byte);
						count_d = count_q + CW'(1);
					end else begin
						res_d.status = crcfr_pkg::ST_OVERFLOW;
					end
					// the store always holds a byte once last arrives
					if (request.last) begin
						pending_d = 1'b1;
						pos_d     = '0;
					end
				end
			end else if (!pending_q) begin
				res_d.status = crcfr_pkg::ST_EMPTY;
			end else begin
				res_d.frame_valid = 1'b1;
				pos_d = pos_q + PW'(1);
				if (pos_q == PW'(0)) begin
					res_d.frame_byte = crcfr_pkg::CH_SOH;
				end else if (pos_q == PW'(1)) begin
					res_d.frame_byte = crc_q[7:0];
				end else if (pos_q == PW'(2)) begin
					res_d.frame_byte = crc_q[15:8];
				end else if (pos_q == PW'(3)) begin
					res_d.frame_byte = crcfr_pkg::CH_STX;
				end else if (pos_off < count_ext) begin
					mem_sel_d = 1'b1;
				end else if (pos_off == count_ext) begin
					res_d.frame_byte = crcfr_pkg::CH_ETX;
				end else begin
					// EOT closes the frame and rearms the block
					res_d.frame_byte = crcfr_pkg::CH_EOT;
					res_d.frame_end  = 1'b1;
					count_d   = '0;
					crc_d     = crcfr_pkg::CRC_INIT;
					pending_d = 1'b0;
					pos_d     = '0;
				end
			end
		end
	end

	crcfr_store #(
		.DEPTH(PAYLOAD_DEPTH),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(count_q[AW-1:0]),
		.wdata(request.data_byte),
		.raddr(pos_off[AW-1:0]),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			crc_q     <= crcfr_pkg::CRC_INIT;
			pending_q <= 1'b0;
			pos_q     <= '0;
			valid_s1  <= 1'b0;
		end else begin
			count_q   <= count_d;
			crc_q     <= crc_d;
			pending_q <= pending_d;
			pos_q     <= pos_d;
			valid_s1  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		res_s1     <= res_d;
		mem_sel_s1 <= mem_sel_d;
	end

	assign busy = valid_s1;
	assign done = valid_s1;

	always_comb begin
		result = res_s1;
		if (mem_sel_s1) begin
			result.frame_byte = mem_rdata;
		end
	end

	`CFR_ASSERT_NEXT(a_result_follows, accept, done, "request gave no result next cycle")
	`CFR_ASSERT_NOW(a_end_is_valid, done && result.frame_end, result.frame_valid, "eot without valid byte")
	`CFR_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(PAYLOAD_DEPTH), "payload count past depth")
	`CFR_ASSERT_NOW(a_idle_pos, !pending_q, pos_q == '0, "read position moved with no frame pending")

endmodule
